// ===== design/slpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, operation and status codes and cell control type for the
// sorted priority list. No dependencies.
package slpq_pkg;

    localparam int NODE_SLOTS_DEF  = 512;
    localparam int WEIGHT_BITS_DEF = 32;

    // fixed field widths of the words
    localparam int KIND_W   = 2;
    localparam int IDX_W_F  = 9;
    localparam int WGT_W_F  = 32;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 10;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    typedef struct packed {
        logic ins;  // open a slot at the sorted position and shift entries at least as heavy right
        logic rem;  // drop the head and shift everything left
    } t_cell_ctl;

endpackage

// ===== design/slpq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for the sorted priority list: command words in,
// result words out. Depends on slpq_pkg.
interface slpq_in_if import slpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W_F-1:0]  node_index;
    logic [WGT_W_F-1:0]  node_weight;

    modport source (output valid, kind, node_index, node_weight, input ready);
    modport sink   (input valid, kind, node_index, node_weight, output ready);
endinterface

interface slpq_out_if import slpq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W_F-1:0]  result_index;
    logic [WGT_W_F-1:0]  result_weight;
    logic [STAT_W-1:0]   status;
    logic [LEN_W-1:0]    list_length;

    modport source (output valid, result_index, result_weight, status, list_length,
                    input ready);
    modport sink   (input valid, result_index, result_weight, status, list_length,
                    output ready);
endinterface

// ===== design/slpq_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a node index and weight, shifts with its
// neighbours on insert and remove. Depends on slpq_pkg.
module slpq_cell import slpq_pkg::*; #(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [IDX_W_F-1:0]     i_new_idx,
    input  logic [WEIGHT_BITS-1:0] i_new_wgt,
    input  logic                   i_left_vld,
    input  logic [IDX_W_F-1:0]     i_left_idx,
    input  logic [WEIGHT_BITS-1:0] i_left_wgt,
    input  logic                   i_left_ge,
    input  logic                   i_right_vld,
    input  logic [IDX_W_F-1:0]     i_right_idx,
    input  logic [WEIGHT_BITS-1:0] i_right_wgt,
    output logic                   o_vld,
    output logic [IDX_W_F-1:0]     o_idx,
    output logic [WEIGHT_BITS-1:0] o_wgt,
    output logic                   o_ge
);

    logic                   r_vld;
    logic [IDX_W_F-1:0]     r_idx;
    logic [WEIGHT_BITS-1:0] r_wgt;

    // empty cells count as heavier, so a word heavier than all listed ones lands in the first free one
    assign o_ge  = !r_vld || (r_wgt >= i_new_wgt);
    assign o_vld = r_vld;
    assign o_idx = r_idx;
    assign o_wgt = r_wgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.rem) begin
            r_vld <= i_right_vld;
        end else if (i_ctl.ins) begin
            if (i_left_ge) begin
                r_vld <= i_left_vld;
            end else if (o_ge) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rem) begin
            r_idx <= i_right_idx;
            r_wgt <= i_right_wgt;
        end else if (i_ctl.ins) begin
            if (i_left_ge) begin
                r_idx <= i_left_idx;
                r_wgt <= i_left_wgt;
            end else if (o_ge) begin
                r_idx <= i_new_idx;
                r_wgt <= i_new_wgt;
            end
        end
    end

endmodule

// ===== design/slpq_member.sv =====
`timescale 1ns / 1ps
// Membership store: one bit per node slot, set while the node is listed.
// Cleared by a sweep after reset. Depends on slpq_pkg.
module slpq_member import slpq_pkg::*; #(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF,
    localparam int IDX_W     = $clog2(NODE_SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic             o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic             i_wr_data,
    output logic             o_clr_busy
);

    logic             r_mem [NODE_SLOTS];
    logic             r_rd_data;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(NODE_SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/sorted_linked_priority_queue.sv =====
`timescale 1ns / 1ps
// Sorted priority list over a chain of NODE_SLOTS cells, lightest node at cell 0.
// A word reads the membership store when accepted; in the execute state it updates
// the chain and loads the result register, stalling while that is full, and no new
// word is accepted until then. Reset empties the chain, then a sweep clears the
// membership store while no word is accepted. Allocator restarts at NODE_SLOTS/2.
module sorted_linked_priority_queue import slpq_pkg::*; #(
    parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slpq_in_if.sink     i_in,
    slpq_out_if.source  o_out
);

    localparam int IDX_W = $clog2(NODE_SLOTS);
    localparam int CNT_W = $clog2(NODE_SLOTS + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [KIND_W-1:0]      r_kind;
    logic [IDX_W_F-1:0]     r_idx;
    logic [WEIGHT_BITS-1:0] r_wgt;
    logic                   r_oor;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_free;

    logic                   r_out_valid;
    logic [IDX_W_F-1:0]     r_res_idx;
    logic [WGT_W_F-1:0]     r_res_wgt;
    logic [STAT_W-1:0]      r_status;
    logic [LEN_W-1:0]       r_len;

    logic                   w_accept, w_out_free, w_fire;
    logic                   w_ins_ok, w_rem_ok, w_alloc_ok;
    logic                   w_member, w_clr_busy;
    t_cell_ctl              w_ctl;

    logic [NODE_SLOTS-1:0]  w_vld, w_ge;
    logic [IDX_W_F-1:0]     w_cidx [NODE_SLOTS];
    logic [WEIGHT_BITS-1:0] w_cwgt [NODE_SLOTS];

    assign i_in.ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_fire       = (r_state == ST_EXEC) && w_out_free;

    assign w_ins_ok   = (r_kind == KIND_INSERT) && !r_oor && !w_member;
    assign w_rem_ok   = (r_kind == KIND_REMOVE) && w_vld[0];
    assign w_alloc_ok = (r_kind == KIND_ALLOC) && (r_free < CNT_W'(NODE_SLOTS));

    assign w_ctl.ins = w_fire && w_ins_ok;
    assign w_ctl.rem = w_fire && w_rem_ok;

    slpq_member #(.NODE_SLOTS(NODE_SLOTS)) u_member (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (IDX_W'(i_in.node_index)),
        .o_rd_data  (w_member),
        .i_wr_en    (w_ctl.ins || w_ctl.rem),
        .i_wr_addr  (w_ins_ok ? IDX_W'(r_idx) : IDX_W'(w_cidx[0])),
        .i_wr_data  (w_ins_ok),
        .o_clr_busy (w_clr_busy)
    );

    for (genvar g = 0; g < NODE_SLOTS; g++) begin : g_cell
        logic                   w_lv, w_lg, w_rv;
        logic [IDX_W_F-1:0]     w_li, w_ri;
        logic [WEIGHT_BITS-1:0] w_lw, w_rw;

        if (g == 0) begin : g_first
            assign w_lv = 1'b0;
            assign w_lg = 1'b0;
            assign w_li = '0;
            assign w_lw = '0;
        end else begin : g_mid
            assign w_lv = w_vld[g-1];
            assign w_lg = w_ge[g-1];
            assign w_li = w_cidx[g-1];
            assign w_lw = w_cwgt[g-1];
        end

        if (g == NODE_SLOTS - 1) begin : g_last
            assign w_rv = 1'b0;
            assign w_ri = '0;
            assign w_rw = '0;
        end else begin : g_body
            assign w_rv = w_vld[g+1];
            assign w_ri = w_cidx[g+1];
            assign w_rw = w_cwgt[g+1];
        end

        slpq_cell #(.WEIGHT_BITS(WEIGHT_BITS)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new_idx   (r_idx),
            .i_new_wgt   (r_wgt),
            .i_left_vld  (w_lv),
            .i_left_idx  (w_li),
            .i_left_wgt  (w_lw),
            .i_left_ge   (w_lg),
            .i_right_vld (w_rv),
            .i_right_idx (w_ri),
            .i_right_wgt (w_rw),
            .o_vld       (w_vld[g]),
            .o_idx       (w_cidx[g]),
            .o_wgt       (w_cwgt[g]),
            .o_ge        (w_ge[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (!w_clr_busy) n_state = ST_IDLE;
            ST_IDLE:  if (w_accept) n_state = ST_EXEC;
            ST_EXEC:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_count <= '0;
            r_free  <= CNT_W'(NODE_SLOTS / 2);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_fire && w_alloc_ok) begin
                r_free <= r_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in.kind;
            r_idx  <= i_in.node_index;
            r_wgt  <= WEIGHT_BITS'(i_in.node_weight);
            r_oor  <= int'(i_in.node_index) >= NODE_SLOTS;
        end
    end

    // result register: parts the chain from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res_idx <= '0;
            r_res_wgt <= '0;
            r_status  <= STAT_OK;
            r_len     <= LEN_W'(n_count);
            unique case (r_kind)
                KIND_INSERT: begin
                    if (!w_ins_ok) r_status <= STAT_INVALID;
                end
                KIND_REMOVE: begin
                    if (w_rem_ok) begin
                        r_res_idx <= w_cidx[0];
                        r_res_wgt <= WGT_W_F'(w_cwgt[0]);
                    end else begin
                        r_status <= STAT_EMPTY;
                    end
                end
                KIND_ALLOC: begin
                    if (w_alloc_ok) begin
                        r_res_idx <= IDX_W_F'(r_free);
                    end else begin
                        r_status <= STAT_INVALID;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_index  = r_res_idx;
    assign o_out.result_weight = r_res_wgt;
    assign o_out.status        = r_status;
    assign o_out.list_length   = r_len;

    // count tracks the occupied cells
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == int'(r_count))
        else $error("list count differs from occupied cells");

    // occupied cells stay packed at the head end
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld >> 1) & ~w_vld) == '0)
        else $error("gap in cell chain");

    // no word taken while the membership sweep runs
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !i_in.ready)
        else $error("word accepted during clearing sweep");

    // every accepted word is in the execute state in the cycle after its accept
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted word not executed");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_linked_priority_queue: directed table, then random
// fill/drain/mixed phases, results checked against a behavioural copy of the list.
// Depends on slpq_pkg, slpq_if and the design top level.
module tb_top;
    import slpq_pkg::*;

    localparam int SLOTS   = NODE_SLOTS_DEF;
    localparam int NO_NODE = SLOTS;
    localparam int PHASES  = 9;
    localparam int PHASE_WORDS = 205;
    localparam int HOLD_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef enum int {MIX_MIXED, MIX_FILL, MIX_DRAIN} t_mix;

    typedef struct packed {
        logic [IDX_W_F-1:0] idx;
        logic [WGT_W_F-1:0] wgt;
        logic [STAT_W-1:0]  stat;
        logic [LEN_W-1:0]   len;
    } t_result;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W_F-1:0] idx;
        logic [WGT_W_F-1:0] wgt;
        bit                 typed;
        t_result            want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    slpq_in_if  cmd_if ();
    slpq_out_if res_if ();

    sorted_linked_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // behavioural copy of the list
    int             link_of   [SLOTS];
    logic [31:0]    weight_of [SLOTS];
    bit             listed    [SLOTS];
    int             first_node = NO_NODE;
    int             node_count = 0;
    int             alloc_next = SLOTS / 2;

    t_result        pending_results [$];
    t_result        got_want;
    int             fault_count = 0;
    int             gap_pct     = 0;
    int             stall_pct   = 0;
    int             hold_left   = 0;
    bit             hold_req    = 0;

    t_mix phase_mix  [PHASES] = '{MIX_MIXED, MIX_FILL, MIX_FILL, MIX_FILL, MIX_FILL,
                                  MIX_DRAIN, MIX_DRAIN, MIX_MIXED, MIX_MIXED};
    int   phase_gap  [PHASES] = '{0, 46, 0, 24, 0, 46, 0, 24, 0};
    int   phase_stall[PHASES] = '{0, 0, 46, 24, 0, 0, 46, 24, 0};

    t_row plan [25];

    function automatic t_result list_apply(input logic [KIND_W-1:0] k,
                                           input logic [IDX_W_F-1:0] ni,
                                           input logic [WGT_W_F-1:0] nw);
        t_result r;
        int      prev;
        int      cur;
        int      steps;
        bit      placed;
        r = '0;
        case (k)
            KIND_INSERT: begin
                if (listed[ni]) begin
                    r.stat = STAT_INVALID;
                end else begin
                    weight_of[ni] = nw;
                    listed[ni] = 1'b1;
                    if (node_count == 0 || first_node >= SLOTS ||
                        weight_of[first_node] >= nw) begin
                        link_of[ni] = (node_count == 0) ? NO_NODE : first_node;
                        first_node = int'(ni);
                    end else begin
                        // walk to the first node at least as heavy
                        prev   = first_node;
                        cur    = link_of[prev];
                        steps  = 1;
                        placed = 1'b0;
                        while (!placed && cur < SLOTS && steps < node_count) begin
                            if (weight_of[cur] >= nw) begin
                                link_of[ni]   = cur;
                                link_of[prev] = int'(ni);
                                placed = 1'b1;
                            end else begin
                                prev = cur;
                                cur  = link_of[cur];
                                steps++;
                            end
                        end
                        if (!placed) begin
                            link_of[ni]   = NO_NODE;
                            link_of[prev] = int'(ni);
                        end
                    end
                    node_count++;
                    r.stat = STAT_OK;
                end
            end
            KIND_REMOVE: begin
                if (node_count == 0 || first_node >= SLOTS) begin
                    r.stat = STAT_EMPTY;
                end else begin
                    r.idx = first_node[IDX_W_F-1:0];
                    r.wgt = weight_of[first_node];
                    listed[first_node] = 1'b0;
                    cur = link_of[first_node];
                    link_of[first_node] = NO_NODE;
                    first_node = cur;
                    node_count--;
                    if (node_count == 0)
                        first_node = NO_NODE;
                end
            end
            KIND_ALLOC: begin
                if (alloc_next >= SLOTS) begin
                    r.stat = STAT_INVALID;
                end else begin
                    r.idx = alloc_next[IDX_W_F-1:0];
                    alloc_next++;
                end
            end
            default: ;
        endcase
        r.len = node_count[LEN_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fault_count++;
        end
    endtask

    task automatic send_word(input logic [KIND_W-1:0] k, input logic [IDX_W_F-1:0] ni,
                             input logic [WGT_W_F-1:0] nw, input bit typed,
                             input t_result typed_want);
        t_result guess;
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= k;
        cmd_if.node_index  <= ni;
        cmd_if.node_weight <= nw;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        guess = list_apply(k, ni, nw);
        if (typed)
            guess = typed_want;
        pending_results = {pending_results, guess};
        while ($urandom_range(99) < gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // sender pauses until every outstanding result word is back
    task automatic settle_out();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_word(input t_mix mix, output logic [KIND_W-1:0] k,
                             output logic [IDX_W_F-1:0] ni, output logic [WGT_W_F-1:0] nw);
        int r;
        int ins_p;
        int rem_p;
        int base;
        case (mix)
            MIX_FILL:  begin ins_p = 86; rem_p = 3;  end
            MIX_DRAIN: begin ins_p = 3;  rem_p = 90; end
            default:   begin ins_p = 32; rem_p = 30; end
        endcase
        r = $urandom_range(99);
        if (r < 3)                  k = KIND_SPARE;
        else if (r < 3 + ins_p)     k = KIND_INSERT;
        else if (r < 3 + ins_p + rem_p) k = KIND_REMOVE;
        else                        k = KIND_ALLOC;

        ni = IDX_W_F'($urandom_range(SLOTS - 1));
        if (k == KIND_INSERT && $urandom_range(99) < 80) begin
            // mostly pick a free slot so the list actually grows
            base = int'(ni);
            for (int s = 0; s < SLOTS; s++) begin
                if (!listed[(base + s) % SLOTS]) begin
                    ni = IDX_W_F'((base + s) % SLOTS);
                    break;
                end
            end
        end

        r = $urandom_range(99);
        if (r < 40)      nw = WGT_W_F'($urandom_range(15));  // plenty of ties
        else if (r < 55) nw = '0;
        else if (r < 65) nw = '1;
        else if (r < 75) nw = 32'hFFFF_FFF0 | WGT_W_F'($urandom_range(15));
        else             nw = $urandom;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: check accepted words, then decide ready for the next edge
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: stray result word, expected none, got idx %0d wgt %0d",
                         $time, res_if.result_index, res_if.result_weight);
                fault_count++;
            end else begin
                got_want = pending_results.pop_front();
                check_field("result_index",  32'(got_want.idx),  32'(res_if.result_index));
                check_field("result_weight", got_want.wgt,       res_if.result_weight);
                check_field("status",        32'(got_want.stat), 32'(res_if.status));
                check_field("list_length",   32'(got_want.len),  32'(res_if.list_length));
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        t_result             none;
        logic [KIND_W-1:0]   k;
        logic [IDX_W_F-1:0]  ni;
        logic [WGT_W_F-1:0]  nw;
        none = '0;
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.kind        = KIND_INSERT;
        cmd_if.node_index  = '0;
        cmd_if.node_weight = '0;

        plan = '{
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b1, '{9'd0,   32'd0, STAT_EMPTY,   10'd0}},
            '{KIND_SPARE,  9'd511, 32'hFFFF_FFFF,  1'b1, '{9'd0,   32'd0, STAT_OK,      10'd0}},
            '{KIND_ALLOC,  9'd0,   32'd0,          1'b1, '{9'd256, 32'd0, STAT_OK,      10'd0}},
            '{KIND_INSERT, 9'd0,   32'd0,          1'b1, '{9'd0,   32'd0, STAT_OK,      10'd1}},
            '{KIND_INSERT, 9'd0,   32'd7,          1'b1, '{9'd0,   32'd0, STAT_INVALID, 10'd1}},
            '{KIND_INSERT, 9'd511, 32'hFFFF_FFFF,  1'b1, '{9'd0,   32'd0, STAT_OK,      10'd2}},
            '{KIND_INSERT, 9'd5,   32'd0,          1'b0, '0},  // newest leads among equals
            '{KIND_INSERT, 9'd8,   32'hFFFF_FFFF,  1'b0, '0},
            '{KIND_INSERT, 9'd300, 32'd100,        1'b0, '0},
            '{KIND_INSERT, 9'd301, 32'd100,        1'b0, '0},
            '{KIND_INSERT, 9'd2,   32'd99,         1'b0, '0},
            '{KIND_INSERT, 9'd3,   32'h8000_0000,  1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_ALLOC,  9'd0,   32'd0,          1'b0, '0},
            '{KIND_INSERT, 9'd5,   32'd0,          1'b0, '0},
            '{KIND_INSERT, 9'd511, 32'd1,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0},
            '{KIND_REMOVE, 9'd0,   32'd0,          1'b0, '0}   // list empty again
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r])
            send_word(plan[r].kind, plan[r].idx, plan[r].wgt, plan[r].typed, plan[r].want);
        settle_out();

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct   = phase_gap[ph];
            stall_pct = phase_stall[ph];
            // long receiver hold while the list is filling
            if (ph == 2)
                hold_req = 1'b1;
            repeat (PHASE_WORDS) begin
                pick_word(phase_mix[ph], k, ni, nw);
                send_word(k, ni, nw, 1'b0, none);
            end
            settle_out();
        end

        repeat (10) @(posedge i_clk);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
